// ----- rtl/core/tsq_pkg.sv -----
// Shared types and constants for the transmit slot queue.
// Holds the item, result and slot payload structs, slot and controller codes.
// No dependencies.
package tsq_pkg;

    // Command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SERVICE = 1'b1;

    // Status frame contents
    localparam logic [7:0] STATUS_LEN_CODE = 8'h85;
    localparam logic [7:0] STATUS_OPCODE   = 8'h01;

    // High-water mark saturates here
    localparam int MARK_W = 4;
    localparam logic [MARK_W-1:0] MARK_MAX = 4'd15;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_OPEN    = 2'd1,
        SLOT_PENDING = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_EXEC = 2'd1,
        CTL_RESP = 2'd2
    } ctl_state_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] frame_id;
        logic [7:0]  length_code;
        logic [63:0] frame_data;
        logic [2:0]  client_count;
        logic        all_ready;
        logic [7:0]  other_high_water;
    } in_item_t;

    typedef struct packed {
        logic              accepted;
        logic              overflow;
        logic              sent;
        logic [31:0]       out_id;
        logic [7:0]        out_length_code;
        logic [63:0]       out_data;
        logic [MARK_W-1:0] high_water;
    } out_item_t;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  length_code;
        logic [63:0] data;
    } slot_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
        logic respond;
    } ctl_cmd_t;

endpackage

// ----- rtl/core/tsq_ctrl.sv -----
// Controller for the transmit slot queue: accept, execute, respond sequence.
// Depends on tsq_pkg for the state enum and command struct.
module tsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output tsq_pkg::ctl_cmd_t cmd
);
    import tsq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        busy        = 1'b0;
        done        = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.respond = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                cmd.capture = start;
                if (start)
                begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
                state_next  = CTL_RESP;
            end
            CTL_RESP:
            begin
                // the result goes out while the next transfer may be taken
                done        = 1'b1;
                cmd.respond = 1'b1;
                cmd.capture = start;
                state_next  = start ? CTL_EXEC : CTL_IDLE;
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) busy |=> done)
        else $error("execute cycle not followed by result strobe");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transfer did not start execution");

endmodule

// ----- rtl/core/tsq_dpath.sv -----
// Datapath for the transmit slot queue: slot states, payload memory, marks.
// Depends on tsq_pkg for types and constants; driven by tsq_ctrl commands.
module tsq_dpath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tsq_pkg::ctl_cmd_t  cmd,
    input  tsq_pkg::in_item_t  item,
    output tsq_pkg::out_item_t result
);
    import tsq_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CAND_W = SLOT_W + 1;
    localparam int CMP_W  = (CAND_W > MARK_W) ? CAND_W : MARK_W;

    in_item_t          item_reg;
    slot_state_t       status_reg  [QUEUE_DEPTH];
    slot_state_t       status_next [QUEUE_DEPTH];
    logic [2:0]        known_reg;
    logic [MARK_W-1:0] mark_reg;
    logic [MARK_W-1:0] mark_next;
    logic              acc_reg;
    logic              ovf_reg;
    logic              sent_reg;
    slot_entry_t       rd_reg;
    slot_entry_t       payload_mem [QUEUE_DEPTH];

    logic              is_service;
    logic              status_due;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              ins_en;
    logic [CAND_W-1:0] mark_cand;
    logic [CMP_W-1:0]  mark_cmp;
    logic [MARK_W-1:0] mark_sat;
    logic              pick_found;
    logic [SLOT_W-1:0] pick_idx;
    logic              take;
    slot_entry_t       wr_entry;
    logic [63:0]       status_data;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        is_service = (item_reg.cmd == CMD_SERVICE);
        status_due = is_service && (item_reg.client_count != known_reg);

        // lowest free slot
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--)
        begin
            if (status_reg[k] == SLOT_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
        ins_en = free_found && (!is_service || status_due);

        mark_cand = {1'b0, free_idx} + CAND_W'(1);
        mark_cmp  = CMP_W'(mark_cand);
        mark_sat  = (mark_cmp > CMP_W'(MARK_MAX)) ? MARK_MAX : mark_cmp[MARK_W-1:0];
        mark_next = (ins_en && (mark_sat > mark_reg)) ? mark_sat : mark_reg;

        // lowest open slot, counting a status frame queued this step
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--)
        begin
            if ((status_reg[k] == SLOT_OPEN) || (ins_en && (free_idx == SLOT_W'(k))))
            begin
                pick_found = 1'b1;
                pick_idx   = SLOT_W'(k);
            end
        end
        take = is_service && pick_found && ((item_reg.client_count == 3'd0) || item_reg.all_ready);

        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            status_next[k] = status_reg[k];
            if (is_service && (status_reg[k] == SLOT_PENDING))
            begin
                status_next[k] = SLOT_FREE;
            end
            if (ins_en && (free_idx == SLOT_W'(k)))
            begin
                status_next[k] = SLOT_OPEN;
            end
            if (take && (pick_idx == SLOT_W'(k)))
            begin
                status_next[k] = SLOT_PENDING;
            end
        end

        status_data = {24'h0, {(8 - MARK_W){1'b0}}, mark_reg, item_reg.other_high_water,
                       5'h0, item_reg.client_count, 8'h00, STATUS_OPCODE};
        if (is_service)
        begin
            wr_entry.id          = 32'h0;
            wr_entry.length_code = STATUS_LEN_CODE;
            wr_entry.data        = status_data;
        end
        else
        begin
            wr_entry.id          = item_reg.frame_id;
            wr_entry.length_code = item_reg.length_code;
            wr_entry.data        = item_reg.frame_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                status_reg[k] <= SLOT_FREE;
            end
            known_reg <= '0;
            mark_reg  <= '0;
        end
        else if (cmd.execute)
        begin
            status_reg <= status_next;
            mark_reg   <= mark_next;
            if (is_service)
            begin
                known_reg <= item_reg.client_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            acc_reg  <= !is_service && free_found;
            ovf_reg  <= !free_found && (!is_service || status_due);
            sent_reg <= take && (item_reg.client_count != 3'd0);
        end
    end

    // payload memory, write-first on a same-slot read
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (ins_en)
            begin
                payload_mem[free_idx] <= wr_entry;
            end
            rd_reg <= (ins_en && (free_idx == pick_idx)) ? wr_entry : payload_mem[pick_idx];
        end
    end

    always_comb
    begin
        result.accepted        = acc_reg;
        result.overflow        = ovf_reg;
        result.sent            = sent_reg;
        result.out_id          = sent_reg ? rd_reg.id : 32'h0;
        result.out_length_code = sent_reg ? rd_reg.length_code : 8'h0;
        result.out_data        = sent_reg ? rd_reg.data : 64'h0;
        result.high_water      = mark_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n) mark_reg >= $past(mark_reg))
        else $error("high-water mark decreased");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.respond && sent_reg) |-> (item_reg.cmd == CMD_SERVICE))
        else $error("frame sent on an enqueue");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> !(acc_reg && ovf_reg))
        else $error("accepted and overflow both set");

endmodule

// ----- rtl/core/tx_slot_queue_broadcast.sv -----
// Transmit slot queue with broadcast: top level joining controller and datapath.
// The result strobe comes in the respond state, after the execute state, which does the slot scan
// plus payload memory write and registered read; a new item is taken while the result is out.
// The receiver cannot stall; done marks each result for one cycle.
// Reset clears all slots to free, the known client count and the high-water mark.
module tx_slot_queue_broadcast #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tsq_pkg::in_item_t  item,
    output logic               done,
    output tsq_pkg::out_item_t result
);
    import tsq_pkg::*;

    ctl_cmd_t ctl_cmd;

    tsq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (ctl_cmd)
    );

    tsq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ctl_cmd),
        .item   (item),
        .result (result)
    );

endmodule
